@@ rtl/dlm_pkg.sv @@
`default_nettype none

package dlm_pkg;

    // default sizes of the stores
    localparam int OUT_MAX_DEF = 64;
    localparam int IN_MAX_DEF  = 512;

    // field and register widths
    localparam int OP_W    = 2;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 9;
    localparam int WORD_W  = 32;
    localparam int IN_CNT_W  = 10;
    localparam int OUT_CNT_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 10;

    // reset values of the count registers
    localparam logic [IN_CNT_W-1:0]  IN_CNT_RST  = 10'd512;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_RST = 7'd64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 1'b1;

    // input word operation codes
    typedef enum logic [OP_W-1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_ACT    = 2'd2
    } op_t;

    // float unit operation
    typedef enum logic {
        FOP_MUL = 1'b0,
        FOP_ADD = 1'b1
    } fop_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BIAS,
        ST_BIAS_WAIT,
        ST_READ,
        ST_MUL,
        ST_MUL_WAIT,
        ST_ADD,
        ST_ADD_WAIT,
        ST_ACC,
        ST_OUT
    } state_t;

    // store write strobes
    typedef struct packed {
        logic weight;
        logic bias;
        logic act;
    } wr_sel_t;

    // default quiet nan for invalid operations
    localparam logic [WORD_W-1:0] QNAN_DEF = 32'hFFC0_0000;

endpackage

`default_nettype wire

@@ rtl/dlm_in_if.sv @@
`default_nettype none

interface dlm_in_if;
    logic                           valid;
    logic                           ready;
    logic [dlm_pkg::OP_W-1:0]       operation;
    logic [dlm_pkg::ROW_W-1:0]      row;
    logic [dlm_pkg::COL_W-1:0]      column;
    logic [dlm_pkg::WORD_W-1:0]     value;
    logic                           vector_end;

    modport source (output valid, operation, row, column, value, vector_end, input ready);
    modport sink (input valid, operation, row, column, value, vector_end, output ready);
endinterface

`default_nettype wire

@@ rtl/dlm_out_if.sv @@
`default_nettype none

interface dlm_out_if;
    logic                           valid;
    logic                           ready;
    logic [dlm_pkg::ROW_W-1:0]      out_index;
    logic [dlm_pkg::WORD_W-1:0]     out_value;
    logic                           out_last;

    modport source (output valid, out_index, out_value, out_last, input ready);
    modport sink (input valid, out_index, out_value, out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/dlm_store.sv @@
`default_nettype none

module dlm_store #(
    parameter int OUT_MAX = dlm_pkg::OUT_MAX_DEF,
    parameter int IN_MAX  = dlm_pkg::IN_MAX_DEF,
    parameter int JW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1,
    parameter int IW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1,
    parameter int WAW = (OUT_MAX * IN_MAX > 1) ? $clog2(OUT_MAX * IN_MAX) : 1
) (
    input  wire                           clk,
    input  dlm_pkg::wr_sel_t              wr,
    input  wire [WAW-1:0]                 w_waddr,
    input  wire [JW-1:0]                  b_waddr,
    input  wire [IW-1:0]                  a_waddr,
    input  wire [dlm_pkg::WORD_W-1:0]     wdata,
    input  wire [WAW-1:0]                 w_raddr,
    input  wire [JW-1:0]                  b_raddr,
    input  wire [IW-1:0]                  a_raddr,
    output logic [dlm_pkg::WORD_W-1:0]    w_rdata,
    output logic [dlm_pkg::WORD_W-1:0]    b_rdata,
    output logic [dlm_pkg::WORD_W-1:0]    a_rdata
);

    logic [dlm_pkg::WORD_W-1:0] weight_mem [OUT_MAX*IN_MAX];
    logic [dlm_pkg::WORD_W-1:0] bias_mem   [OUT_MAX];
    logic [dlm_pkg::WORD_W-1:0] act_mem    [IN_MAX];

    // weight store
    always_ff @(posedge clk)
    begin
        if (wr.weight)
        begin
            weight_mem[w_waddr] <= wdata;
        end
        w_rdata <= weight_mem[w_raddr];
    end

    // bias store
    always_ff @(posedge clk)
    begin
        if (wr.bias)
        begin
            bias_mem[b_waddr] <= wdata;
        end
        b_rdata <= bias_mem[b_raddr];
    end

    // activation buffer
    always_ff @(posedge clk)
    begin
        if (wr.act)
        begin
            act_mem[a_waddr] <= wdata;
        end
        a_rdata <= act_mem[a_raddr];
    end

endmodule

`default_nettype wire

@@ rtl/dlm_fpu.sv @@
`default_nettype none

module dlm_fpu (
    input  wire                           clk,
    input  dlm_pkg::fop_t                 op,
    input  wire [dlm_pkg::WORD_W-1:0]     a,
    input  wire [dlm_pkg::WORD_W-1:0]     b,
    output logic [dlm_pkg::WORD_W-1:0]    res
);

    // normalize, then round to nearest even; value is m * 2^(e - 127 - 47)
    function automatic logic [31:0] round_pack(input logic s, input logic signed [11:0] e,
                                               input logic [47:0] m);
        logic [5:0]         lz;
        logic               found;
        logic [47:0]        mn;
        logic signed [11:0] en;
        logic signed [11:0] sub_gap;
        logic [6:0]         sh;
        logic [95:0]        wide;
        logic               st;
        logic [23:0]        m24;
        logic               up;
        logic [24:0]        r25;
        logic [23:0]        mant;
        logic [31:0]        r;
        lz = 6'd0;
        found = 1'b0;
        for (int k = 47; k >= 0; k--)
        begin
            if (!found && m[k])
            begin
                found = 1'b1;
                lz = 6'(47 - k);
            end
        end
        mn = m << lz;
        en = e - $signed({6'd0, lz});
        st = 1'b0;
        // subnormal range
        if (en < 12'sd1)
        begin
            sub_gap = 12'sd1 - en;
            if (sub_gap > 12'sd49)
            begin
                sh = 7'd49;
            end
            else
            begin
                sh = 7'(sub_gap);
            end
            wide = {mn, 48'd0} >> sh;
            mn = wide[95:48];
            st = |wide[47:0];
            en = 12'sd1;
        end
        m24 = mn[47:24];
        up = mn[23] & (st | (|mn[22:0]) | m24[0]);
        r25 = {1'b0, m24} + {24'd0, up};
        if (r25[24])
        begin
            en = en + 12'sd1;
            mant = r25[24:1];
        end
        else
        begin
            mant = r25[23:0];
        end
        if (en > 12'sd254)
        begin
            r = {s, 8'hFF, 23'd0};
        end
        else
        begin
            r = {s, (mant[23] ? en[7:0] : 8'h00), mant[22:0]};
        end
        return r;
    endfunction

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [7:0]  ea_n, eb_n;
    logic [23:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]  e_big, e_small, d;
    logic [23:0] m_big, m_small;
    logic        s_big;
    logic [53:0] sm_wide;
    logic [26:0] sm_al;
    logic [27:0] sum;

    logic                       spec_next;
    logic [31:0]                spec_val_next;
    logic                       sign_next;
    logic signed [11:0]         exp_next;
    logic [47:0]                mant_next;

    logic                       spec_reg;
    logic [31:0]                spec_val_reg;
    logic                       sign_reg;
    logic signed [11:0]         exp_reg;
    logic [47:0]                mant_reg;

    // operand unpack
    always_comb
    begin
        sa = a[31];
        sb = b[31];
        ea = a[30:23];
        eb = b[30:23];
        ea_n = (ea == 8'd0) ? 8'd1 : ea;
        eb_n = (eb == 8'd0) ? 8'd1 : eb;
        ma = {ea != 8'd0, a[22:0]};
        mb = {eb != 8'd0, b[22:0]};
        a_nan = (ea == 8'hFF) && (a[22:0] != 23'd0);
        b_nan = (eb == 8'hFF) && (b[22:0] != 23'd0);
        a_inf = (ea == 8'hFF) && (a[22:0] == 23'd0);
        b_inf = (eb == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
    end

    // alignment for the adder
    always_comb
    begin
        if (a[30:0] >= b[30:0])
        begin
            s_big = sa;
            e_big = ea_n;
            e_small = eb_n;
            m_big = ma;
            m_small = mb;
        end
        else
        begin
            s_big = sb;
            e_big = eb_n;
            e_small = ea_n;
            m_big = mb;
            m_small = ma;
        end
        d = e_big - e_small;
        sm_wide = {m_small, 3'd0, 27'd0} >> d;
        sm_al = {sm_wide[53:28], sm_wide[27] | (|sm_wide[26:0])};
        if (sa == sb)
        begin
            sum = {1'b0, m_big, 3'd0} + {1'b0, sm_al};
        end
        else
        begin
            sum = {1'b0, m_big, 3'd0} - {1'b0, sm_al};
        end
    end

    // first stage: specials, product or aligned sum
    always_comb
    begin
        spec_next = 1'b0;
        spec_val_next = 32'd0;
        sign_next = 1'b0;
        exp_next = 12'sd0;
        mant_next = 48'd0;
        unique case (op)
            dlm_pkg::FOP_MUL:
            begin
                sign_next = sa ^ sb;
                exp_next = $signed({4'd0, ea_n}) + $signed({4'd0, eb_n}) - 12'sd126;
                mant_next = ma * mb;
                spec_next = 1'b1;
                if (a_nan)
                begin
                    spec_val_next = a | 32'h0040_0000;
                end
                else if (b_nan)
                begin
                    spec_val_next = b | 32'h0040_0000;
                end
                else if ((a_inf && b_zero) || (b_inf && a_zero))
                begin
                    spec_val_next = dlm_pkg::QNAN_DEF;
                end
                else if (a_inf || b_inf)
                begin
                    spec_val_next = {sa ^ sb, 8'hFF, 23'd0};
                end
                else if (a_zero || b_zero)
                begin
                    spec_val_next = {sa ^ sb, 31'd0};
                end
                else
                begin
                    spec_next = 1'b0;
                end
            end
            dlm_pkg::FOP_ADD:
            begin
                sign_next = s_big;
                exp_next = $signed({4'd0, e_big}) + 12'sd1;
                mant_next = {sum, 20'd0};
                spec_next = 1'b1;
                if (a_nan)
                begin
                    spec_val_next = a | 32'h0040_0000;
                end
                else if (b_nan)
                begin
                    spec_val_next = b | 32'h0040_0000;
                end
                else if (a_inf && b_inf && (sa != sb))
                begin
                    spec_val_next = dlm_pkg::QNAN_DEF;
                end
                else if (a_inf)
                begin
                    spec_val_next = a;
                end
                else if (b_inf)
                begin
                    spec_val_next = b;
                end
                else if (sum == 28'd0)
                begin
                    spec_val_next = {sa & sb, 31'd0};
                end
                else
                begin
                    spec_next = 1'b0;
                end
            end
            default:
            begin
                spec_next = 1'b0;
            end
        endcase
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        spec_reg <= spec_next;
        spec_val_reg <= spec_val_next;
        sign_reg <= sign_next;
        exp_reg <= exp_next;
        mant_reg <= mant_next;
    end

    // second stage: normalize and round
    always_ff @(posedge clk)
    begin
        if (spec_reg)
        begin
            res <= spec_val_reg;
        end
        else
        begin
            res <= round_pack(sign_reg, exp_reg, mant_reg);
        end
    end

endmodule

`default_nettype wire

@@ rtl/dense_layer_matvec_fp32.sv @@
`default_nettype none

// channel   | dir | modport | payload
// in_word   | in  | sink    | operation, row, column, value, vector_end
// out_word  | out | source  | out_index, out_value, out_last
// cfg       | in  | none    | cfg_we, cfg_index, cfg_data
//
// store writes and activation words without the end mark are taken while idle
// the marked activation word starts a pass with one result word per output; each
// multiply-add is a store read, a two-stage multiply and a two-stage add that must
// finish before the next add starts
// rst_n clears the control state and the counts; the stores keep no reset
// input is held off for the whole pass, and a stalled result word stops the pass

module dense_layer_matvec_fp32 #(
    parameter int OUT_MAX = dlm_pkg::OUT_MAX_DEF,
    parameter int IN_MAX  = dlm_pkg::IN_MAX_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    dlm_in_if.sink                              in_word,
    dlm_out_if.source                           out_word,
    input  wire                                 cfg_we,
    input  wire [dlm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire [dlm_pkg::CFG_DAT_W-1:0]        cfg_data
);

    localparam int JW  = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int IW  = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int WAW = (OUT_MAX * IN_MAX > 1) ? $clog2(OUT_MAX * IN_MAX) : 1;

    dlm_pkg::state_t                    state_reg, state_next;
    logic [JW-1:0]                      j_reg, j_next;
    logic [IW-1:0]                      i_reg, i_next;
    logic [dlm_pkg::WORD_W-1:0]         acc_reg, acc_next;
    logic [dlm_pkg::IN_CNT_W-1:0]       in_cnt_reg;
    logic [dlm_pkg::OUT_CNT_W-1:0]      out_cnt_reg;

    logic [IW-1:0]                      i_last;
    logic [JW-1:0]                      j_last;
    logic                               accept;
    dlm_pkg::op_t                       op;
    dlm_pkg::wr_sel_t                   wr;
    logic [WAW-1:0]                     w_waddr, w_raddr;
    logic [dlm_pkg::WORD_W-1:0]         w_rdata, b_rdata, a_rdata;
    dlm_pkg::fop_t                      fop;
    logic [dlm_pkg::WORD_W-1:0]         fpu_a, fpu_b, fpu_res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= dlm_pkg::IN_CNT_RST;
            out_cnt_reg <= dlm_pkg::OUT_CNT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dlm_pkg::REG_INPUT_COUNT)
            begin
                in_cnt_reg <= cfg_data;
            end
            if (cfg_index == dlm_pkg::REG_OUTPUT_COUNT)
            begin
                out_cnt_reg <= cfg_data[dlm_pkg::OUT_CNT_W-1:0];
            end
        end
    end

    // saturated last indexes
    always_comb
    begin
        if (in_cnt_reg == '0)
        begin
            i_last = '0;
        end
        else if (32'(in_cnt_reg) >= IN_MAX)
        begin
            i_last = IW'(IN_MAX - 1);
        end
        else
        begin
            i_last = IW'(in_cnt_reg - 10'd1);
        end
        if (out_cnt_reg == '0)
        begin
            j_last = '0;
        end
        else if (32'(out_cnt_reg) >= OUT_MAX)
        begin
            j_last = JW'(OUT_MAX - 1);
        end
        else
        begin
            j_last = JW'(out_cnt_reg - 7'd1);
        end
    end

    // input decode and store writes
    always_comb
    begin
        accept = in_word.valid && in_word.ready;
        op = dlm_pkg::op_t'(in_word.operation);
        wr.weight = accept && (op == dlm_pkg::OP_WEIGHT)
                    && (32'(in_word.row) < OUT_MAX) && (32'(in_word.column) < IN_MAX);
        wr.bias = accept && (op == dlm_pkg::OP_BIAS) && (32'(in_word.row) < OUT_MAX);
        wr.act = accept && (op == dlm_pkg::OP_ACT) && (32'(in_word.column) < IN_MAX);
        w_waddr = WAW'(32'(in_word.row) * IN_MAX + 32'(in_word.column));
        w_raddr = WAW'(32'(j_reg) * IN_MAX + 32'(i_reg));
    end

    dlm_store #(
        .OUT_MAX (OUT_MAX),
        .IN_MAX  (IN_MAX),
        .JW      (JW),
        .IW      (IW),
        .WAW     (WAW)
    ) u_store (
        .clk     (clk),
        .wr      (wr),
        .w_waddr (w_waddr),
        .b_waddr (JW'(in_word.row)),
        .a_waddr (IW'(in_word.column)),
        .wdata   (in_word.value),
        .w_raddr (w_raddr),
        .b_raddr (j_reg),
        .a_raddr (i_reg),
        .w_rdata (w_rdata),
        .b_rdata (b_rdata),
        .a_rdata (a_rdata)
    );

    // float unit operands
    always_comb
    begin
        if (state_reg == dlm_pkg::ST_ADD)
        begin
            fop = dlm_pkg::FOP_ADD;
            fpu_a = acc_reg;
            fpu_b = fpu_res;
        end
        else
        begin
            fop = dlm_pkg::FOP_MUL;
            fpu_a = a_rdata;
            fpu_b = w_rdata;
        end
    end

    dlm_fpu u_fpu (
        .clk (clk),
        .op  (fop),
        .a   (fpu_a),
        .b   (fpu_b),
        .res (fpu_res)
    );

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dlm_pkg::ST_IDLE;
            j_reg <= '0;
            i_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg <= j_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        j_next = j_reg;
        i_next = i_reg;
        acc_next = acc_reg;
        unique case (state_reg)
            dlm_pkg::ST_IDLE:
            begin
                if (accept && (op == dlm_pkg::OP_ACT) && in_word.vector_end)
                begin
                    j_next = '0;
                    i_next = '0;
                    state_next = dlm_pkg::ST_BIAS;
                end
            end
            dlm_pkg::ST_BIAS:
            begin
                state_next = dlm_pkg::ST_BIAS_WAIT;
            end
            dlm_pkg::ST_BIAS_WAIT:
            begin
                acc_next = b_rdata;
                i_next = '0;
                state_next = dlm_pkg::ST_READ;
            end
            dlm_pkg::ST_READ:
            begin
                state_next = dlm_pkg::ST_MUL;
            end
            dlm_pkg::ST_MUL:
            begin
                state_next = dlm_pkg::ST_MUL_WAIT;
            end
            dlm_pkg::ST_MUL_WAIT:
            begin
                state_next = dlm_pkg::ST_ADD;
            end
            dlm_pkg::ST_ADD:
            begin
                state_next = dlm_pkg::ST_ADD_WAIT;
            end
            dlm_pkg::ST_ADD_WAIT:
            begin
                state_next = dlm_pkg::ST_ACC;
            end
            dlm_pkg::ST_ACC:
            begin
                acc_next = fpu_res;
                if (i_reg == i_last)
                begin
                    state_next = dlm_pkg::ST_OUT;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = dlm_pkg::ST_READ;
                end
            end
            dlm_pkg::ST_OUT:
            begin
                if (out_word.ready)
                begin
                    if (j_reg == j_last)
                    begin
                        state_next = dlm_pkg::ST_IDLE;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                        state_next = dlm_pkg::ST_BIAS;
                    end
                end
            end
            default:
            begin
                state_next = dlm_pkg::ST_IDLE;
            end
        endcase
    end

    // handshake and result word
    assign in_word.ready = (state_reg == dlm_pkg::ST_IDLE);
    assign out_word.valid = (state_reg == dlm_pkg::ST_OUT);
    assign out_word.out_index = dlm_pkg::ROW_W'(j_reg);
    assign out_word.out_value = acc_reg;
    assign out_word.out_last = (j_reg == j_last);

    // checks
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (op == dlm_pkg::OP_ACT) && in_word.vector_end)
        |=> (state_reg == dlm_pkg::ST_BIAS) && (j_reg == '0))
        else $error("marked activation word did not start a pass");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_word.ready && out_word.valid))
        else $error("input taken while a result word is pending");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_word.valid && out_word.ready && out_word.out_last)
        |=> (state_reg == dlm_pkg::ST_IDLE))
        else $error("pass continued after the last result word");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dlm_pkg::ST_IDLE) |-> (i_reg <= i_last) && (j_reg <= j_last))
        else $error("loop index past its count");

endmodule

`default_nettype wire
